// ===== rtl/flv_pkg.sv =====
// ----------------------------------------------------------------------------
// flv_pkg
// Shared types, codes and constants of the FLV container tag parser.
// ----------------------------------------------------------------------------
package flv_pkg;

   // parse phase
   typedef enum logic [2:0] {
      PH_FILE    = 3'd0,
      PH_TAG     = 3'd1,
      PH_PAYLOAD = 3'd2,
      PH_BACK    = 3'd3,
      PH_LOCKED  = 3'd4
   } phase_type;

   // result kind codes
   typedef enum logic [2:0] {
      KIND_HDR_OK   = 3'd0,
      KIND_TAG_HDR  = 3'd1,
      KIND_PAYLOAD  = 3'd2,
      KIND_BAD_SIG  = 3'd3,
      KIND_BAD_BACK = 3'd4
   } kind_type;

   // byte positions inside the file prefix (header plus first back pointer)
   localparam logic [3:0] POS_VERSION    = 4'd3;
   localparam logic [3:0] POS_FLAGS      = 4'd4;
   localparam logic [3:0] POS_BACK_FIRST = 4'd9;
   localparam logic [3:0] FILE_LAST      = 4'd12;

   // byte positions inside a tag header
   localparam logic [3:0] TAG_LEN_LAST   = 4'd3;
   localparam logic [3:0] TAG_STAMP_LAST = 4'd6;
   localparam logic [3:0] TAG_STAMP_EXT  = 4'd7;
   localparam logic [3:0] TAG_LAST       = 4'd10;

   // last byte of a trailing back pointer
   localparam logic [3:0] BACK_LAST      = 4'd3;

   localparam logic [24:0] TAG_HEADER_BYTES = 25'd11;

   // header flag bits
   localparam int FLAG_AUDIO_BIT = 2;
   localparam int FLAG_VIDEO_BIT = 0;

   // one result item
   typedef struct packed {
      kind_type     kind;
      logic [7:0]   version;
      logic         has_audio;
      logic         has_video;
      logic [7:0]   tag_kind;
      logic [23:0]  tag_length;
      logic [31:0]  time_stamp;
      logic [7:0]   payload_byte;
      logic         end_of_tag;
   } result_type;

   // expected signature byte at a given position
   function automatic logic [7:0] sig_byte(input logic [1:0] idx);
      logic [7:0] val;
      begin
         unique case (idx)
            2'd0:    val = 8'h46;
            2'd1:    val = 8'h4C;
            2'd2:    val = 8'h56;
            default: val = 8'h00;
         endcase
         return val;
      end
   endfunction

endpackage

// ===== rtl/flv_container_tag_parser_top.sv =====
// ----------------------------------------------------------------------------
// flv_container_tag_parser_top
// FLV container demultiplexer: checks the file header, splits tags into
// header results and payload bytes, and checks every back pointer.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock cycle, with no gaps of its own:
// each accepted beat is held in an input register, decoded in one pass
// against the parse state, and any result lands in an output register. The
// output register decouples the two sides; a stall on rsp_tready holds the
// input register, and req_tready drops only while both are full. Header
// bytes, tag header bytes before the last and good back pointer bytes give
// no result. A bad signature or back pointer gives one error result and
// then every later byte is swallowed until reset.
module flv_container_tag_parser_top (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // stream_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // version[7:0], has_audio[8], has_video[9], tag_kind[17:10],
   // tag_length[41:18], time_stamp[73:42], payload_byte[81:74], zero pad
   output logic [87:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,   // kind
   output logic        rsp_tlast    // end_of_tag
);

   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff, in_byte_in;
   logic                rsp_valid_ff, rsp_valid_in;
   flv_pkg::result_type rsp_data_ff, rsp_data_in;
   flv_pkg::result_type core_result;
   logic                core_valid;
   logic                advance;

   // input stage moves on when the output register is free or draining
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   flv_parse_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .in_byte      (in_byte_ff),
      .result_valid (core_valid),
      .result       (core_result)
   );

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = core_valid;
         rsp_data_in  = core_result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   // result beat packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.kind;
   assign rsp_tlast  = rsp_data_ff.end_of_tag;
   assign rsp_tdata  = {6'd0,
                        rsp_data_ff.payload_byte,
                        rsp_data_ff.time_stamp,
                        rsp_data_ff.tag_length,
                        rsp_data_ff.tag_kind,
                        rsp_data_ff.has_video,
                        rsp_data_ff.has_audio,
                        rsp_data_ff.version};

endmodule

// ===== rtl/flv_parse_core.sv =====
// ----------------------------------------------------------------------------
// flv_parse_core
// Parse state and single-pass decode of one stream byte into at most one
// result item.
// ----------------------------------------------------------------------------
module flv_parse_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          in_byte,
   output logic                result_valid,
   output flv_pkg::result_type result
);

   flv_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  pos_ff, pos_in;
   logic [23:0] bytes_left_ff, bytes_left_in;
   logic [7:0]  held_kind_ff, held_kind_in;
   logic [23:0] held_length_ff, held_length_in;
   logic [31:0] held_stamp_ff, held_stamp_in;
   logic [31:0] back_pointer_ff, back_pointer_in;
   logic [7:0]  version_ff, version_in;
   logic [7:0]  flags_ff, flags_in;
   logic        sig_ok_ff, sig_ok_in;

   logic [31:0] bp_shift;
   logic [23:0] bytes_left_dec;
   logic [31:0] bp_expected;
   logic        file_done, tag_done, back_done, len_zero, left_done;
   logic        bp_bad;

   // shared decode terms
   assign bp_shift       = {back_pointer_ff[23:0], in_byte};
   assign bytes_left_dec = bytes_left_ff - 24'd1;
   assign bp_expected    = {7'd0, {1'b0, held_length_ff} + flv_pkg::TAG_HEADER_BYTES};
   assign file_done      = (pos_ff == flv_pkg::FILE_LAST);
   assign tag_done       = (pos_ff == flv_pkg::TAG_LAST);
   assign back_done      = (pos_ff == flv_pkg::BACK_LAST);
   assign len_zero       = (held_length_ff == 24'd0);
   assign left_done      = (bytes_left_dec == 24'd0);
   assign bp_bad         = (bp_shift != bp_expected);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         unique case (phase_ff)
            flv_pkg::PH_FILE: begin
               if (file_done) begin
                  if (!sig_ok_ff || (bp_shift != 32'd0)) phase_in = flv_pkg::PH_LOCKED;
                  else phase_in = flv_pkg::PH_TAG;
               end
            end
            flv_pkg::PH_TAG: begin
               if (tag_done) phase_in = len_zero ? flv_pkg::PH_BACK : flv_pkg::PH_PAYLOAD;
            end
            flv_pkg::PH_PAYLOAD: begin
               if (left_done) phase_in = flv_pkg::PH_BACK;
            end
            flv_pkg::PH_BACK: begin
               if (back_done) phase_in = bp_bad ? flv_pkg::PH_LOCKED : flv_pkg::PH_TAG;
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // field capture and result
   always_comb begin
      pos_in          = pos_ff;
      bytes_left_in   = bytes_left_ff;
      held_kind_in    = held_kind_ff;
      held_length_in  = held_length_ff;
      held_stamp_in   = held_stamp_ff;
      back_pointer_in = back_pointer_ff;
      version_in      = version_ff;
      flags_in        = flags_ff;
      sig_ok_in       = sig_ok_ff;
      result_valid    = 1'b0;
      result          = '0;
      if (step) begin
         unique case (phase_ff)
            flv_pkg::PH_FILE: begin
               if (pos_ff < flv_pkg::POS_VERSION) begin
                  if (in_byte != flv_pkg::sig_byte(pos_ff[1:0])) sig_ok_in = 1'b0;
               end else if (pos_ff == flv_pkg::POS_VERSION) begin
                  version_in = in_byte;
               end else if (pos_ff == flv_pkg::POS_FLAGS) begin
                  flags_in = in_byte;
               end else if (pos_ff >= flv_pkg::POS_BACK_FIRST) begin
                  back_pointer_in = bp_shift;
               end
               if (file_done) begin
                  pos_in       = 4'd0;
                  result_valid = 1'b1;
                  if (!sig_ok_ff) begin
                     result.kind = flv_pkg::KIND_BAD_SIG;
                  end else if (bp_shift != 32'd0) begin
                     result.kind = flv_pkg::KIND_BAD_BACK;
                  end else begin
                     back_pointer_in  = 32'd0;
                     result.kind      = flv_pkg::KIND_HDR_OK;
                     result.version   = version_ff;
                     result.has_audio = flags_ff[flv_pkg::FLAG_AUDIO_BIT];
                     result.has_video = flags_ff[flv_pkg::FLAG_VIDEO_BIT];
                  end
               end else begin
                  pos_in = pos_ff + 4'd1;
               end
            end
            flv_pkg::PH_TAG: begin
               if (pos_ff == 4'd0) begin
                  held_kind_in   = in_byte;
                  held_length_in = 24'd0;
                  held_stamp_in  = 32'd0;
               end else if (pos_ff <= flv_pkg::TAG_LEN_LAST) begin
                  held_length_in = {held_length_ff[15:0], in_byte};
               end else if (pos_ff <= flv_pkg::TAG_STAMP_LAST) begin
                  held_stamp_in = {8'd0, held_stamp_ff[15:0], in_byte};
               end else if (pos_ff == flv_pkg::TAG_STAMP_EXT) begin
                  held_stamp_in = {in_byte, held_stamp_ff[23:0]};
               end
               if (tag_done) begin
                  pos_in            = 4'd0;
                  result_valid      = 1'b1;
                  result.kind       = flv_pkg::KIND_TAG_HDR;
                  result.tag_kind   = held_kind_ff;
                  result.tag_length = held_length_ff;
                  result.time_stamp = held_stamp_ff;
                  result.end_of_tag = len_zero;
                  if (len_zero) back_pointer_in = 32'd0;
                  else bytes_left_in = held_length_ff;
               end else begin
                  pos_in = pos_ff + 4'd1;
               end
            end
            flv_pkg::PH_PAYLOAD: begin
               result_valid        = 1'b1;
               result.kind         = flv_pkg::KIND_PAYLOAD;
               result.tag_kind     = held_kind_ff;
               result.tag_length   = held_length_ff;
               result.time_stamp   = held_stamp_ff;
               result.payload_byte = in_byte;
               bytes_left_in       = bytes_left_dec;
               if (left_done) begin
                  result.end_of_tag = 1'b1;
                  back_pointer_in   = 32'd0;
                  pos_in            = 4'd0;
               end
            end
            flv_pkg::PH_BACK: begin
               back_pointer_in = bp_shift;
               if (back_done) begin
                  pos_in = 4'd0;
                  if (bp_bad) begin
                     result_valid = 1'b1;
                     result.kind  = flv_pkg::KIND_BAD_BACK;
                  end else begin
                     back_pointer_in = 32'd0;
                  end
               end else begin
                  pos_in = pos_ff + 4'd1;
               end
            end
            default: begin
               result_valid = 1'b0;
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= flv_pkg::PH_FILE;
         pos_ff          <= 4'd0;
         bytes_left_ff   <= 24'd0;
         held_kind_ff    <= 8'd0;
         held_length_ff  <= 24'd0;
         held_stamp_ff   <= 32'd0;
         back_pointer_ff <= 32'd0;
         version_ff      <= 8'd0;
         flags_ff        <= 8'd0;
         sig_ok_ff       <= 1'b1;
      end else begin
         phase_ff        <= phase_in;
         pos_ff          <= pos_in;
         bytes_left_ff   <= bytes_left_in;
         held_kind_ff    <= held_kind_in;
         held_length_ff  <= held_length_in;
         held_stamp_ff   <= held_stamp_in;
         back_pointer_ff <= back_pointer_in;
         version_ff      <= version_in;
         flags_ff        <= flags_in;
         sig_ok_ff       <= sig_ok_in;
      end
   end

endmodule
